// ===== hdl/weight_quantizer_rgba8_macros.svh =====
// assertion macros for the weight quantizer
`ifndef WEIGHT_QUANTIZER_RGBA8_MACROS_SVH
`define WEIGHT_QUANTIZER_RGBA8_MACROS_SVH
`ifndef SYNTHESIS
`define WQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WQ_ASSERT_SAME(label, clk, rst, ante, cons)
`define WQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/wq_rgba8_pkg.sv =====
// shared types and constants for the weight quantizer
package wq_rgba8_pkg;

  localparam int NumCh = 4;
  localparam int WeightW = 18;
  localparam logic [16:0] OneQ16 = 17'd65536;
  localparam logic [9:0] FullScale = 10'd255;
  localparam logic [9:0] MinTotal = 10'd252;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StSum = 2'd2;

  typedef struct packed {
    logic        bad;
    logic [7:0]  q;
    logic [15:0] rem;
  } lane_t;

endpackage

// ===== hdl/wq_rgba8_lane.sv =====
// one channel lane: range check, scale by 255, split into floor and remainder
module wq_rgba8_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic [wq_rgba8_pkg::WeightW-1:0]  weight,
  output wq_rgba8_pkg::lane_t               lane
);

  logic        bad;
  logic [24:0] scaled;

  assign bad = weight[17] | (weight[16:0] > wq_rgba8_pkg::OneQ16);
  assign scaled = {weight[16:0], 8'd0} - {8'd0, weight[16:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      lane.bad <= bad;
      lane.q   <= scaled[23:16];
      lane.rem <= scaled[15:0];
    end
  end

endmodule

// ===== hdl/wq_rgba8_merge.sv =====
// merge stage: sum check, remainder ranking and final bytes
`include "weight_quantizer_rgba8_macros.svh"
module wq_rgba8_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  input  wq_rgba8_pkg::lane_t lanes [wq_rgba8_pkg::NumCh],
  output logic                done,
  output logic [7:0]          bytes [wq_rgba8_pkg::NumCh],
  output logic [1:0]          status,
  output logic                end_of_batch
);

  logic [9:0] total;
  logic       any_bad;
  logic       sum_ok;
  logic [1:0] missing;
  logic [7:0] bytes_next [wq_rgba8_pkg::NumCh];
  logic [1:0] status_next;

  always_comb begin
    total = '0;
    any_bad = 1'b0;
    for (int i = 0; i < wq_rgba8_pkg::NumCh; i++) begin
      total = total + {2'd0, lanes[i].q};
      any_bad = any_bad | lanes[i].bad;
    end
  end

  assign sum_ok = (total >= wq_rgba8_pkg::MinTotal) && (total <= wq_rgba8_pkg::FullScale);
  assign missing = 2'(wq_rgba8_pkg::FullScale[7:0] - total[7:0]);

  always_comb begin
    logic [2:0] rank;
    for (int i = 0; i < wq_rgba8_pkg::NumCh; i++) begin
      rank = '0;
      for (int j = 0; j < wq_rgba8_pkg::NumCh; j++) begin
        if ((lanes[j].rem > lanes[i].rem) || ((j < i) && (lanes[j].rem == lanes[i].rem)))
          rank = rank + 3'd1;
      end
      if (any_bad || !sum_ok)
        bytes_next[i] = '0;
      else if (rank < {1'b0, missing})
        bytes_next[i] = lanes[i].q + 8'd1;
      else
        bytes_next[i] = lanes[i].q;
    end
    if (any_bad)
      status_next = wq_rgba8_pkg::StRange;
    else if (!sum_ok)
      status_next = wq_rgba8_pkg::StSum;
    else
      status_next = wq_rgba8_pkg::StOk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      bytes        <= bytes_next;
      status       <= status_next;
      end_of_batch <= in_last;
    end
  end

  `WQ_ASSERT_NEXT(a_done_follows, clk, rst, in_valid, done)
  `WQ_ASSERT_SAME(a_err_zero, clk, rst, done && (status != wq_rgba8_pkg::StOk),
    (bytes[0] == 8'd0) && (bytes[1] == 8'd0) && (bytes[2] == 8'd0) && (bytes[3] == 8'd0))
  `WQ_ASSERT_SAME(a_ok_sum, clk, rst, done && (status == wq_rgba8_pkg::StOk),
    ({2'd0, bytes[0]} + {2'd0, bytes[1]} + {2'd0, bytes[2]} + {2'd0, bytes[3]})
      == wq_rgba8_pkg::FullScale)
  `WQ_ASSERT_SAME(a_status_code, clk, rst, done,
    (status == wq_rgba8_pkg::StOk) || (status == wq_rgba8_pkg::StRange)
      || (status == wq_rgba8_pkg::StSum))

endmodule

// ===== hdl/weight_quantizer_rgba8.sv =====
// top level of the rgba8 weight quantizer
// Takes one texel per clock: busy is always low and a start pulse is a transfer. Four
// channel lanes check and scale the weights in the first register stage, and the merge
// stage ranks the remainders and forms the bytes in the second, so the result appears
// on byte_0..byte_3, status and end_of_batch with done high once the merge stage has
// registered it. Results are shown for one cycle only; the receiver cannot stall them.
module weight_quantizer_rgba8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [17:0] weight_0,
  input  logic [17:0] weight_1,
  input  logic [17:0] weight_2,
  input  logic [17:0] weight_3,
  input  logic        last_texel,
  output logic        done,
  output logic [7:0]  byte_0,
  output logic [7:0]  byte_1,
  output logic [7:0]  byte_2,
  output logic [7:0]  byte_3,
  output logic [1:0]  status,
  output logic        end_of_batch
);

  logic                                      accept;
  logic                                      stage_valid;
  logic                                      stage_last;
  logic [wq_rgba8_pkg::WeightW-1:0]          weights [wq_rgba8_pkg::NumCh];
  wq_rgba8_pkg::lane_t                       lanes [wq_rgba8_pkg::NumCh];
  logic [7:0]                                bytes [wq_rgba8_pkg::NumCh];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign weights[0] = weight_0;
  assign weights[1] = weight_1;
  assign weights[2] = weight_2;
  assign weights[3] = weight_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_last <= last_texel;
    end
  end

  for (genvar g = 0; g < wq_rgba8_pkg::NumCh; g++) begin : g_lane
    wq_rgba8_lane u_lane (
      .clk    (clk),
      .en     (accept),
      .weight (weights[g]),
      .lane   (lanes[g])
    );
  end

  wq_rgba8_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (stage_valid),
    .in_last      (stage_last),
    .lanes        (lanes),
    .done         (done),
    .bytes        (bytes),
    .status       (status),
    .end_of_batch (end_of_batch)
  );

  assign byte_0 = bytes[0];
  assign byte_1 = bytes[1];
  assign byte_2 = bytes[2];
  assign byte_3 = bytes[3];

endmodule
